// ===== hw/rtl/x86_16_mov_subset_executor_core_macros.svh =====
// Assertion helpers shared by the executor core
`ifndef X86_16_MOV_SUBSET_EXECUTOR_CORE_MACROS_SVH
`define X86_16_MOV_SUBSET_EXECUTOR_CORE_MACROS_SVH

// same-cycle implication
`define XMOV_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define XMOV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/xmov_pkg.sv =====
package xmov_pkg;

   // fetch addresses at or above this fault
   localparam logic [20:0] MEMORY_BYTES = 21'd1048576;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   localparam logic [15:0] CODE_SEG_RESET = 16'h1000;

   localparam logic [1:0] CSR_CODE_SEG  = 2'd0;
   localparam logic [1:0] CSR_START_OFS = 2'd1;
   localparam logic [1:0] CSR_DATA_SEG  = 2'd2;

   localparam logic [7:0] OP_MOV_R16_FIRST = 8'hB8;
   localparam logic [7:0] OP_MOV_R16_LAST  = 8'hBF;
   localparam logic [7:0] OP_MOV_R8_FIRST  = 8'hB0;
   localparam logic [7:0] OP_MOV_R8_LAST   = 8'hB7;
   localparam logic [7:0] OP_MOV_RM8       = 8'h88;
   localparam logic [7:0] OP_MOV_RM16      = 8'h89;
   localparam logic [7:0] OP_HLT           = 8'hF4;
   localparam logic [1:0] MOD_REGISTER     = 2'b11;

   localparam logic [3:0] DUMP_IP_INDEX = 4'd8;

   typedef enum logic [2:0] {
      EV_PROGRESS = 3'd0,
      EV_WRITE    = 3'd1,
      EV_HALT     = 3'd2,
      EV_UNKNOWN  = 3'd3,
      EV_FAULT    = 3'd4
   } ev_kind_type;

   typedef enum logic [2:0] {
      PH_OPCODE,
      PH_IMM16_LO,
      PH_IMM16_HI,
      PH_IMM8,
      PH_MODRM,
      PH_OFS_LO,
      PH_OFS_HI
   } phase_type;

   // one executed byte, as handed from front to back
   typedef struct packed {
      ev_kind_type kind;
      logic        fault_tail;  // a fault result follows this one
      logic [20:0] next_addr;
      logic [19:0] waddr;
      logic [7:0]  wdata;
   } rec_type;

   typedef struct packed {
      logic [7:0][15:0] gpr;
      logic [15:0]      ip;
   } arch_type;

endpackage

// ===== hw/rtl/xmov_front.sv =====
module xmov_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 csr_we,
   input  logic [1:0]           csr_addr,
   input  logic [15:0]          csr_wdata,
   input  logic                 q_ready,
   output logic                 push,
   output xmov_pkg::rec_type    push_rec,
   output xmov_pkg::arch_type   arch
);

   logic [15:0]         cs_ff, cs_in;
   logic [15:0]         ds_ff, ds_in;
   logic [15:0]         ip_ff, ip_in;
   logic [7:0][15:0]    gpr_ff, gpr_in;
   xmov_pkg::phase_type phase_ff, phase_in;
   logic [7:0]          opcode_ff, opcode_in;
   logic [7:0]          modrm_ff, modrm_in;
   logic [7:0]          low_ff, low_in;
   logic                stopped_ff, stopped_in;

   logic                 run;
   logic [20:0]          cur_addr;
   logic [20:0]          nxt_addr;
   logic [15:0]          ip_inc;
   logic                 halt;
   xmov_pkg::ev_kind_type kind;
   logic [19:0]          waddr;
   logic [7:0]           wdata;

   function automatic logic [7:0] get8(logic [7:0][15:0] r, logic [2:0] idx);
      get8 = idx[2] ? r[idx[1:0]][15:8] : r[idx[1:0]][7:0];
   endfunction

   function automatic logic [7:0][15:0] set8(logic [7:0][15:0] r, logic [2:0] idx,
                                             logic [7:0] b);
      logic [7:0][15:0] t;
      t = r;
      if (idx[2]) begin
         t[idx[1:0]][15:8] = b;
      end else begin
         t[idx[1:0]][7:0] = b;
      end
      return t;
   endfunction

   assign req_tready = stopped_ff || q_ready;
   assign run        = req_tvalid && req_tready && !stopped_ff;
   assign cur_addr   = {1'b0, cs_ff, 4'b0} + {5'b0, ip_ff};
   assign ip_inc     = ip_ff + 16'd1;
   assign nxt_addr   = {1'b0, cs_ff, 4'b0} + {5'b0, ip_inc};
   assign arch.gpr   = gpr_ff;
   assign arch.ip    = ip_ff;

   always_comb begin
      cs_in      = cs_ff;
      ds_in      = ds_ff;
      ip_in      = ip_ff;
      gpr_in     = gpr_ff;
      phase_in   = phase_ff;
      opcode_in  = opcode_ff;
      modrm_in   = modrm_ff;
      low_in     = low_ff;
      stopped_in = stopped_ff;
      halt       = 1'b0;
      kind       = xmov_pkg::EV_PROGRESS;
      waddr      = '0;
      wdata      = '0;
      push       = 1'b0;
      push_rec   = '0;

      if (run) begin
         push = 1'b1;
         if (cur_addr >= xmov_pkg::MEMORY_BYTES) begin
            // byte fetched from outside memory is dropped
            stopped_in         = 1'b1;
            push_rec.kind      = xmov_pkg::EV_FAULT;
            push_rec.next_addr = cur_addr;
         end else begin
            ip_in    = ip_inc;
            phase_in = xmov_pkg::PH_OPCODE;
            unique case (phase_ff)
               xmov_pkg::PH_IMM16_LO: begin
                  low_in   = req_tdata;
                  phase_in = xmov_pkg::PH_IMM16_HI;
               end
               xmov_pkg::PH_IMM16_HI: begin
                  gpr_in[opcode_ff[2:0]] = {req_tdata, low_ff};
               end
               xmov_pkg::PH_IMM8: begin
                  gpr_in = set8(gpr_ff, opcode_ff[2:0], req_tdata);
               end
               xmov_pkg::PH_MODRM: begin
                  modrm_in = req_tdata;
                  if (opcode_ff == xmov_pkg::OP_MOV_RM8) begin
                     if (req_tdata[7:6] == xmov_pkg::MOD_REGISTER) begin
                        gpr_in = set8(gpr_ff, req_tdata[2:0],
                                      get8(gpr_ff, req_tdata[5:3]));
                     end else begin
                        phase_in = xmov_pkg::PH_OFS_LO;
                     end
                  end else if (req_tdata[7:6] == xmov_pkg::MOD_REGISTER) begin
                     gpr_in[req_tdata[2:0]] = gpr_ff[req_tdata[5:3]];
                  end
               end
               xmov_pkg::PH_OFS_LO: begin
                  low_in   = req_tdata;
                  phase_in = xmov_pkg::PH_OFS_HI;
               end
               xmov_pkg::PH_OFS_HI: begin
                  waddr = {ds_ff, 4'b0} + {4'b0, req_tdata, low_ff};
                  wdata = get8(gpr_ff, modrm_ff[5:3]);
                  kind  = xmov_pkg::EV_WRITE;
               end
               default: begin
                  opcode_in = req_tdata;
                  if (req_tdata >= xmov_pkg::OP_MOV_R16_FIRST &&
                      req_tdata <= xmov_pkg::OP_MOV_R16_LAST) begin
                     phase_in = xmov_pkg::PH_IMM16_LO;
                  end else if (req_tdata >= xmov_pkg::OP_MOV_R8_FIRST &&
                               req_tdata <= xmov_pkg::OP_MOV_R8_LAST) begin
                     phase_in = xmov_pkg::PH_IMM8;
                  end else if (req_tdata == xmov_pkg::OP_MOV_RM8 ||
                               req_tdata == xmov_pkg::OP_MOV_RM16) begin
                     phase_in = xmov_pkg::PH_MODRM;
                  end else if (req_tdata == xmov_pkg::OP_HLT) begin
                     halt = 1'b1;
                  end else begin
                     kind = xmov_pkg::EV_UNKNOWN;
                  end
               end
            endcase

            push_rec.next_addr = nxt_addr;
            push_rec.waddr     = waddr;
            push_rec.wdata     = wdata;
            push_rec.kind      = kind;
            if (halt) begin
               stopped_in    = 1'b1;
               push_rec.kind = xmov_pkg::EV_HALT;
            end else if (nxt_addr >= xmov_pkg::MEMORY_BYTES) begin
               // a plain progress word turns into the fault; others get it appended
               stopped_in = 1'b1;
               if (kind == xmov_pkg::EV_PROGRESS) begin
                  push_rec.kind = xmov_pkg::EV_FAULT;
               end else begin
                  push_rec.fault_tail = 1'b1;
               end
            end
         end
      end

      if (csr_we) begin
         unique case (csr_addr)
            xmov_pkg::CSR_CODE_SEG:  cs_in = csr_wdata;
            xmov_pkg::CSR_START_OFS: ip_in = csr_wdata;
            xmov_pkg::CSR_DATA_SEG:  ds_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cs_ff      <= xmov_pkg::CODE_SEG_RESET;
         ds_ff      <= '0;
         ip_ff      <= '0;
         gpr_ff     <= '0;
         phase_ff   <= xmov_pkg::PH_OPCODE;
         opcode_ff  <= '0;
         modrm_ff   <= '0;
         low_ff     <= '0;
         stopped_ff <= 1'b0;
      end else begin
         cs_ff      <= cs_in;
         ds_ff      <= ds_in;
         ip_ff      <= ip_in;
         gpr_ff     <= gpr_in;
         phase_ff   <= phase_in;
         opcode_ff  <= opcode_in;
         modrm_ff   <= modrm_in;
         low_ff     <= low_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// ===== hw/rtl/xmov_queue.sv =====
module xmov_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  xmov_pkg::rec_type push_rec,
   output logic              q_ready,
   input  logic              pop,
   output logic              head_valid,
   output xmov_pkg::rec_type head_rec
);

   xmov_pkg::rec_type                  mem_ff [xmov_pkg::Q_DEPTH];
   logic [xmov_pkg::Q_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [xmov_pkg::Q_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [xmov_pkg::Q_CNT_W-1:0]       count_ff, count_in;

   assign q_ready    = count_ff != xmov_pkg::Q_CNT_W'(xmov_pkg::Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_rec   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// ===== hw/rtl/xmov_back.sv =====
module xmov_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  xmov_pkg::rec_type  head_rec,
   output logic               pop,
   input  xmov_pkg::arch_type arch,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [71:0]        rsp_tdata,  // next_fetch_addr, write_addr, write_data,
                                          // dump_index, dump_value, zero pad
   output logic [2:0]         rsp_tuser,  // event_kind
   output logic               rsp_tlast   // last_of_run
);

   logic        valid_ff, valid_in;
   logic [3:0]  sub_ff, sub_in;
   logic [2:0]  kind_ff, kind_in;
   logic [20:0] addr_ff, addr_in;
   logic [19:0] waddr_ff, waddr_in;
   logic [7:0]  wdata_ff, wdata_in;
   logic [3:0]  idx_ff, idx_in;
   logic [15:0] val_ff, val_in;
   logic        last_ff, last_in;
   logic        issue;

   assign issue      = head_valid && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {3'b0, val_ff, idx_ff, wdata_ff, waddr_ff, addr_ff};

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      sub_in   = sub_ff;
      kind_in  = kind_ff;
      addr_in  = addr_ff;
      waddr_in = waddr_ff;
      wdata_in = wdata_ff;
      idx_in   = idx_ff;
      val_in   = val_ff;
      last_in  = last_ff;
      pop      = 1'b0;

      if (issue) begin
         valid_in = 1'b1;
         kind_in  = head_rec.kind;
         addr_in  = head_rec.next_addr;
         waddr_in = head_rec.waddr;
         wdata_in = head_rec.wdata;
         idx_in   = '0;
         val_in   = '0;
         last_in  = 1'b1;
         if (head_rec.kind == xmov_pkg::EV_HALT) begin
            // dump walks the eight registers, then IP
            idx_in  = sub_ff;
            val_in  = (sub_ff == xmov_pkg::DUMP_IP_INDEX) ? arch.ip : arch.gpr[sub_ff[2:0]];
            last_in = sub_ff == xmov_pkg::DUMP_IP_INDEX;
            if (last_in) begin
               pop    = 1'b1;
               sub_in = '0;
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end else if (head_rec.fault_tail && sub_ff == '0) begin
            last_in = 1'b0;
            sub_in  = 4'd1;
         end else if (head_rec.fault_tail) begin
            kind_in  = xmov_pkg::EV_FAULT;
            waddr_in = '0;
            wdata_in = '0;
            pop      = 1'b1;
            sub_in   = '0;
         end else begin
            pop = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      addr_ff  <= addr_in;
      waddr_ff <= waddr_in;
      wdata_ff <= wdata_in;
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      last_ff  <= last_in;
   end

endmodule

// ===== hw/rtl/x86_16_mov_subset_executor_core.sv =====
// A code byte accepted is written to the queue, then registered in the result stage as its first result word.
// Throughput: one code byte per cycle while the queue has room; HLT emits nine dump words and a
//   write or unknown opcode that runs off the end of memory emits two, set by the back end.
// A two-entry queue between decode and the result stage absorbs output stalls.
// Reset (synchronous, active high): registers and IP zero, CS 1000h, DS 0, decode idle.
`include "x86_16_mov_subset_executor_core_macros.svh"

module x86_16_mov_subset_executor_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // code_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // next_fetch_addr, write_addr, write_data,
                                    // dump_index, dump_value, zero pad
   output logic [2:0]  rsp_tuser,   // event_kind
   output logic        rsp_tlast,   // last_of_run
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic               q_push;
   logic               q_ready;
   logic               q_pop;
   logic               head_valid;
   xmov_pkg::rec_type  push_rec;
   xmov_pkg::rec_type  head_rec;
   xmov_pkg::arch_type arch;
   logic               rsp_is_fault;
   logic               rsp_is_dump_end;
   logic               rsp_dump_ip;
   logic               halt_pop;

   xmov_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_ready    (q_ready),
      .push       (q_push),
      .push_rec   (push_rec),
      .arch       (arch)
   );

   xmov_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (push_rec),
      .q_ready    (q_ready),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   xmov_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (q_pop),
      .arch       (arch),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_is_fault    = rsp_tvalid && rsp_tuser == xmov_pkg::EV_FAULT;
   assign rsp_is_dump_end = rsp_tvalid && rsp_tuser == xmov_pkg::EV_HALT && rsp_tlast;
   assign rsp_dump_ip     = rsp_tdata[52:49] == xmov_pkg::DUMP_IP_INDEX;
   assign halt_pop        = q_pop && head_rec.kind == xmov_pkg::EV_HALT;

   `XMOV_ASSERT_IMPLY(a_no_overflow, clock, reset, q_push, q_ready, "queue overflow")
   `XMOV_ASSERT_IMPLY(a_fault_is_last, clock, reset, rsp_is_fault, rsp_tlast, "fault word not last")
   `XMOV_ASSERT_IMPLY(a_dump_ends_ip, clock, reset, rsp_is_dump_end, rsp_dump_ip, "dump ends early")
   `XMOV_ASSERT_NEXT(a_halt_pops, clock, reset, halt_pop, !head_valid, "work queued after halt")

endmodule

// ===== dv/x86_16_mov_subset_executor_core_tb.sv =====
`timescale 1ns / 1ps

module x86_16_mov_subset_executor_core_tb;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BYTES = 72;
   localparam int NUM_PHASES = 6;
   localparam int HOLD_CYCLES = 80;

   // opcodes outside the decoded set
   localparam logic [7:0] OP_UNKNOWN_LOW  = 8'h00;
   localparam logic [7:0] OP_UNKNOWN_HIGH = 8'hFF;
   localparam logic [7:0] BYTE_NOT_HLT    = 8'h90;

   localparam logic [1:0] MOD_MEM_NODISP = 2'b00;
   localparam logic [1:0] MOD_MEM_DISP16 = 2'b10;

   typedef enum {
      END_HALT,
      END_FAULT_AT_FETCH,
      END_FAULT_AFTER_STEP,
      END_FAULT_AFTER_WRITE,
      END_FAULT_AFTER_UNKNOWN
   } run_end_type;

   typedef struct packed {
      xmov_pkg::ev_kind_type kind;
      logic [20:0] naddr;
      logic [19:0] waddr;
      logic [7:0]  wdata;
      logic [3:0]  didx;
      logic [15:0] dval;
      logic        last;
   } fetch_result_type;

   class mov_scoreboard;
      logic [15:0]         code_seg;
      logic [15:0]         start_ofs;
      logic [15:0]         data_seg;
      logic [15:0]         gpr [8];
      logic [15:0]         ip;
      xmov_pkg::phase_type phase;
      logic [7:0]          op_hold;
      logic [7:0]          modrm_hold;
      logic [7:0]          lo_hold;
      bit                  stopped;
      fetch_result_type    pending_words[$];
      int                  errors;
      int                  bytes_executed;
      int                  words_checked;
      int                  kind_count [5];

      function new();
         code_seg = xmov_pkg::CODE_SEG_RESET;
         start_ofs = '0;
         data_seg = '0;
         foreach (gpr[i]) gpr[i] = '0;
         ip = '0;
         phase = xmov_pkg::PH_OPCODE;
         op_hold = '0;
         modrm_hold = '0;
         lo_hold = '0;
         stopped = 1'b0;
         errors = 0;
         bytes_executed = 0;
         words_checked = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [15:0] v);
         case (idx)
            xmov_pkg::CSR_CODE_SEG: code_seg = v;
            xmov_pkg::CSR_START_OFS: begin
               start_ofs = v;
               ip = v;
            end
            xmov_pkg::CSR_DATA_SEG: data_seg = v;
            default: ;
         endcase
      endfunction

      function logic [20:0] fetch_addr();
         return {1'b0, code_seg, 4'h0} + {5'h0, ip};
      endfunction

      // byte regs: 0..3 low halves of AX,CX,DX,BX, 4..7 high halves
      function logic [7:0] get8(logic [2:0] idx);
         return idx[2] ? gpr[idx[1:0]][15:8] : gpr[idx[1:0]][7:0];
      endfunction

      function void set8(logic [2:0] idx, logic [7:0] v);
         if (idx[2]) gpr[idx[1:0]][15:8] = v;
         else gpr[idx[1:0]][7:0] = v;
      endfunction

      function bit at_opcode();
         return phase == xmov_pkg::PH_OPCODE;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void add_word(xmov_pkg::ev_kind_type k, logic [20:0] na, logic [19:0] wa,
                             logic [7:0] wd, logic [3:0] di, logic [15:0] dv, logic l);
         fetch_result_type w;
         w.kind = k;
         w.naddr = na;
         w.waddr = wa;
         w.wdata = wd;
         w.didx = di;
         w.dval = dv;
         w.last = l;
         pending_words.push_back(w);
      endfunction

      function void note_byte(logic [7:0] b);
         logic [20:0]           addr;
         logic [19:0]           waddr;
         logic [7:0]            wdata;
         xmov_pkg::ev_kind_type kind;
         bit                    halt;
         if (stopped) return;
         kind = xmov_pkg::EV_PROGRESS;
         waddr = '0;
         wdata = '0;
         halt = 1'b0;
         addr = fetch_addr();
         // fetch from past the top of memory: byte dropped, block stops
         if (addr >= xmov_pkg::MEMORY_BYTES) begin
            stopped = 1'b1;
            add_word(xmov_pkg::EV_FAULT, addr, '0, '0, '0, '0, 1'b1);
            return;
         end
         bytes_executed++;
         ip = ip + 16'd1;
         case (phase)
            xmov_pkg::PH_IMM16_LO: begin
               lo_hold = b;
               phase = xmov_pkg::PH_IMM16_HI;
            end
            xmov_pkg::PH_IMM16_HI: begin
               gpr[op_hold[2:0]] = {b, lo_hold};
               phase = xmov_pkg::PH_OPCODE;
            end
            xmov_pkg::PH_IMM8: begin
               set8(op_hold[2:0], b);
               phase = xmov_pkg::PH_OPCODE;
            end
            xmov_pkg::PH_MODRM: begin
               modrm_hold = b;
               phase = xmov_pkg::PH_OPCODE;
               if (op_hold == xmov_pkg::OP_MOV_RM8) begin
                  if (b[7:6] == xmov_pkg::MOD_REGISTER) set8(b[2:0], get8(b[5:3]));
                  else phase = xmov_pkg::PH_OFS_LO;
               end else if (b[7:6] == xmov_pkg::MOD_REGISTER) begin
                  gpr[b[2:0]] = gpr[b[5:3]];
               end
            end
            xmov_pkg::PH_OFS_LO: begin
               lo_hold = b;
               phase = xmov_pkg::PH_OFS_HI;
            end
            xmov_pkg::PH_OFS_HI: begin
               waddr = {data_seg, 4'h0} + {4'h0, b, lo_hold};
               wdata = get8(modrm_hold[5:3]);
               kind = xmov_pkg::EV_WRITE;
               phase = xmov_pkg::PH_OPCODE;
            end
            default: begin
               phase = xmov_pkg::PH_OPCODE;
               op_hold = b;
               if (b >= xmov_pkg::OP_MOV_R16_FIRST && b <= xmov_pkg::OP_MOV_R16_LAST)
                  phase = xmov_pkg::PH_IMM16_LO;
               else if (b >= xmov_pkg::OP_MOV_R8_FIRST && b <= xmov_pkg::OP_MOV_R8_LAST)
                  phase = xmov_pkg::PH_IMM8;
               else if (b == xmov_pkg::OP_MOV_RM8 || b == xmov_pkg::OP_MOV_RM16)
                  phase = xmov_pkg::PH_MODRM;
               else if (b == xmov_pkg::OP_HLT) halt = 1'b1;
               else kind = xmov_pkg::EV_UNKNOWN;
            end
         endcase
         addr = fetch_addr();
         if (halt) begin
            stopped = 1'b1;
            for (int i = 0; i < 8; i++)
               add_word(xmov_pkg::EV_HALT, addr, '0, '0, 4'(i), gpr[i], 1'b0);
            add_word(xmov_pkg::EV_HALT, addr, '0, '0, xmov_pkg::DUMP_IP_INDEX, ip, 1'b1);
         end else if (addr >= xmov_pkg::MEMORY_BYTES) begin
            // next fetch out of range: progress turns into fault, others get a trailer
            stopped = 1'b1;
            if (kind != xmov_pkg::EV_PROGRESS)
               add_word(kind, addr, waddr, wdata, '0, '0, 1'b0);
            add_word(xmov_pkg::EV_FAULT, addr, '0, '0, '0, '0, 1'b1);
         end else begin
            add_word(kind, addr, waddr, wdata, '0, '0, 1'b1);
         end
      endfunction

      function void compare(string name, logic [31:0] exp_val, logic [31:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_word(logic [2:0] user, logic [71:0] data, logic last);
         fetch_result_type w;
         if (pending_words.size() == 0) begin
            $error("result word with none pending: kind %0d addr %0h", user, data[20:0]);
            errors++;
            return;
         end
         w = pending_words.pop_front();
         words_checked++;
         kind_count[int'(w.kind)]++;
         compare("event_kind", w.kind, user);
         compare("next_fetch_addr", w.naddr, data[20:0]);
         compare("write_addr", w.waddr, data[40:21]);
         compare("write_data", w.wdata, data[48:41]);
         compare("dump_index", w.didx, data[52:49]);
         compare("dump_value", w.dval, data[68:53]);
         compare("last_of_run", w.last, last);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   mov_scoreboard sb;
   int unsigned   cycle_count = 0;
   int            bytes_sent = 0;
   bit            source_idles = 1'b1;
   bit            sink_idles = 1'b1;
   bit            long_hold = 1'b0;
   bit            halt_allowed = 1'b0;
   run_end_type   run_end;

   x86_16_mov_subset_executor_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count, sb.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // result sink: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end else if (sink_idles && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic bit is_decoded_opcode(logic [7:0] b);
      return (b >= xmov_pkg::OP_MOV_R8_FIRST && b <= xmov_pkg::OP_MOV_R16_LAST) ||
             b == xmov_pkg::OP_MOV_RM8 || b == xmov_pkg::OP_MOV_RM16 ||
             b == xmov_pkg::OP_HLT;
   endfunction

   function automatic logic [7:0] modrm_byte(logic [1:0] md, logic [2:0] rg, logic [2:0] rm);
      return {md, rg, rm};
   endfunction

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic push_byte(input logic [7:0] b);
      logic [7:0] v;
      v = b;
      if (!halt_allowed && sb.at_opcode() && v == xmov_pkg::OP_HLT) v = BYTE_NOT_HLT;
      if (source_idles && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(v);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic realign();
      while (!sb.at_opcode()) push_byte(rnd8());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] cs, input logic [15:0] ofs,
                             input logic [15:0] ds);
      write_csr(xmov_pkg::CSR_CODE_SEG, cs);
      write_csr(xmov_pkg::CSR_START_OFS, ofs);
      write_csr(xmov_pkg::CSR_DATA_SEG, ds);
      csr_we <= 1'b0;
   endtask

   task automatic send_random_instr();
      int         pick;
      logic [7:0] modrm;
      logic [7:0] op;
      realign();
      pick = $urandom_range(0, 99);
      modrm = rnd8();
      if (pick < 24) begin
         push_byte(xmov_pkg::OP_MOV_R16_FIRST + 8'($urandom_range(0, 7)));
         push_byte(rnd8());
         push_byte(rnd8());
      end else if (pick < 44) begin
         push_byte(xmov_pkg::OP_MOV_R8_FIRST + 8'($urandom_range(0, 7)));
         push_byte(rnd8());
      end else if (pick < 64) begin
         if ($urandom_range(0, 1) == 1) modrm[7:6] = xmov_pkg::MOD_REGISTER;
         push_byte(xmov_pkg::OP_MOV_RM8);
         push_byte(modrm);
         if (modrm[7:6] != xmov_pkg::MOD_REGISTER) begin
            push_byte(rnd8());
            push_byte(rnd8());
         end
      end else if (pick < 76) begin
         if ($urandom_range(0, 1) == 1) modrm[7:6] = xmov_pkg::MOD_REGISTER;
         push_byte(xmov_pkg::OP_MOV_RM16);
         push_byte(modrm);
      end else if (pick < 88) begin
         do op = rnd8(); while (is_decoded_opcode(op));
         push_byte(op);
      end else begin
         // stray byte, possibly a cut-off instruction
         push_byte(rnd8());
      end
   endtask

   initial begin
      int start;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset config
      push_byte(xmov_pkg::OP_MOV_R16_LAST); push_byte(8'h34); push_byte(8'h12);
      push_byte(xmov_pkg::OP_MOV_R16_FIRST); push_byte(8'hFF); push_byte(8'hFF);
      push_byte(xmov_pkg::OP_MOV_R8_FIRST + 8'd4); push_byte(8'h00);
      push_byte(xmov_pkg::OP_MOV_R8_LAST); push_byte(8'hFF);
      push_byte(xmov_pkg::OP_MOV_RM8);
      push_byte(modrm_byte(xmov_pkg::MOD_REGISTER, 3'd0, 3'd7));
      push_byte(xmov_pkg::OP_MOV_RM8);
      push_byte(modrm_byte(xmov_pkg::MOD_REGISTER, 3'd4, 3'd1));
      push_byte(xmov_pkg::OP_MOV_RM16);
      push_byte(modrm_byte(xmov_pkg::MOD_REGISTER, 3'd7, 3'd0));
      push_byte(xmov_pkg::OP_MOV_RM16); push_byte(modrm_byte(MOD_MEM_NODISP, 3'd0, 3'd6));
      push_byte(xmov_pkg::OP_MOV_RM8); push_byte(modrm_byte(MOD_MEM_NODISP, 3'd0, 3'd6));
      push_byte(8'hFF); push_byte(8'hFF);
      push_byte(xmov_pkg::OP_MOV_RM8); push_byte(modrm_byte(MOD_MEM_DISP16, 3'd7, 3'd6));
      push_byte(8'h00); push_byte(8'h00);
      push_byte(OP_UNKNOWN_LOW); push_byte(OP_UNKNOWN_HIGH);
      drain();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: set_config(16'h0000, 16'h0000, 16'h0000);
            // top code segment that stays in range, IP wraps, store address wraps
            1: set_config(16'hF000, 16'hFFF0, 16'hFFFF);
            default: set_config(16'($urandom_range(0, 16'hF000)), 16'($urandom),
                                16'($urandom));
         endcase
         if (p == 1) long_hold = 1'b1;
         if (p == NUM_PHASES - 1) begin
            source_idles = 1'b0;
            sink_idles = 1'b0;
         end
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) send_random_instr();
         drain();
      end

      // one stop per run: halt or one of the fault flavors
      realign();
      drain();
      run_end = run_end_type'($urandom_range(0, 4));
      case (run_end)
         END_HALT: begin
            halt_allowed = 1'b1;
            push_byte(xmov_pkg::OP_HLT);
         end
         END_FAULT_AT_FETCH: begin
            set_config(16'hFFFF, 16'h0010, 16'($urandom));
            push_byte(rnd8());
         end
         END_FAULT_AFTER_STEP: begin
            set_config(16'hFFFF, 16'h000F, 16'($urandom));
            push_byte(xmov_pkg::OP_MOV_R8_FIRST);
         end
         END_FAULT_AFTER_WRITE: begin
            set_config(16'hFFFF, 16'h000C, 16'($urandom));
            push_byte(xmov_pkg::OP_MOV_RM8);
            push_byte(modrm_byte(MOD_MEM_NODISP, 3'($urandom_range(0, 7)), 3'd6));
            push_byte(rnd8());
            push_byte(rnd8());
         end
         default: begin
            set_config(16'hFFFF, 16'h000F, 16'($urandom));
            push_byte(OP_UNKNOWN_LOW);
         end
      endcase
      // stopped: these must be swallowed without a result
      halt_allowed = 1'b1;
      repeat (3) push_byte(rnd8());

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      if (sb.pending() != 0) begin
         $error("%0d result words never arrived", sb.pending());
         sb.errors++;
      end
      $display("%0d code bytes sent, %0d executed; %0d result words checked", bytes_sent,
               sb.bytes_executed, sb.words_checked);
      $display("progress %0d, store %0d, dump %0d, unknown %0d, fault %0d; stop by %s",
               sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
               sb.kind_count[4], run_end.name());
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/xmov_pkg.sv
hw/rtl/xmov_front.sv
hw/rtl/xmov_queue.sv
hw/rtl/xmov_back.sv
hw/rtl/x86_16_mov_subset_executor_core.sv
dv/x86_16_mov_subset_executor_core_tb.sv
